/* rtl/lps_pkg.sv */
// Shared types and constants for the laptop power sequencer core.
// No dependencies; every other rtl file refers to this package by scoped name.
`default_nettype none

package lps_pkg;

  localparam int unsigned CntW   = 9;
  localparam int unsigned BlinkW = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned IdxW   = 2;

  // rail sequence milestones, in ticks after the accepted press
  localparam logic [CntW-1:0] SeqBtnHigh = 9'd3;
  localparam logic [CntW-1:0] SeqStby    = 9'd110;
  localparam logic [CntW-1:0] SeqBtnLow  = 9'd180;
  localparam logic [CntW-1:0] SeqEnd     = 9'd300;

  localparam logic [BlinkW-1:0] BlinkMax = '1;

  localparam logic [7:0]        DebounceRst = 8'd100;
  localparam logic [BlinkW-1:0] BlinkRst    = 12'd1000;
  localparam logic [7:0]        SettleRst   = 8'd100;

  typedef enum logic [IdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_BLINK    = 2'd1,
    CFG_SETTLE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PS_DEFAULT = 3'd0,
    PS_DS5     = 3'd1,
    PS_S5      = 3'd2,
    PS_S3      = 3'd3,
    PS_S0      = 3'd4
  } pstate_e;

  typedef enum logic [1:0] {
    PH_SETTLE   = 2'd0,
    PH_IDLE     = 2'd1,
    PH_DEBOUNCE = 2'd2,
    PH_RAIL     = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0]        debounce_ticks;
    logic [BlinkW-1:0] blink_ticks;
    logic [7:0]        settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic               slp_s3_high;
    logic               slp_s5_high;
    logic               lid_open;
    logic               adapter_absent;
    logic               button_line;
    logic               platform_reset_line;
    logic               battery_present;
    logic signed [15:0] batt_current;
  } in_word_t;

  typedef struct packed {
    logic       rail_enable;
    logic       button_out_n;
    logic       standby_reset_n;
    logic       power_led;
    logic       amber_led;
    logic       white_led;
    logic       fan_reset_pulse;
    logic       charger_enable;
    logic       charger_off_pulse;
    logic       cycle_restart_pulse;
    logic [2:0] power_state_code;
    logic       busy_res;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/lps_cfg.sv */
// Configuration registers of the power sequencer: debounce, blink and settle.
// Depends on lps_pkg.
`default_nettype none

module lps_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lps_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [lps_pkg::CfgW-1:0]  cfg_wdata_i,
  output lps_pkg::cfg_t                  cfg_o
);

  lps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lps_pkg::cfg_idx_e'(cfg_idx_i))
        lps_pkg::CFG_DEBOUNCE: cfg_d.debounce_ticks = cfg_wdata_i[7:0];
        lps_pkg::CFG_BLINK:    cfg_d.blink_ticks    = cfg_wdata_i;
        lps_pkg::CFG_SETTLE:   cfg_d.settle_ticks   = cfg_wdata_i[7:0];
        default:               cfg_d = cfg_q;   // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= lps_pkg::DebounceRst;
      cfg_q.blink_ticks    <= lps_pkg::BlinkRst;
      cfg_q.settle_ticks   <= lps_pkg::SettleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/lps_tick.sv */
// Per-tick sequencer state and next-state logic: settle, debounce, rail
// sequence, edge pulses and LEDs. Depends on lps_pkg.
`default_nettype none

module lps_tick (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire lps_pkg::in_word_t   word_i,
  input  wire lps_pkg::cfg_t       cfg_i,
  output lps_pkg::out_word_t       word_o
);

  lps_pkg::phase_e               phase_q, phase_d;
  lps_pkg::pstate_e              cs_q, cs_d;
  logic [lps_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [lps_pkg::BlinkW-1:0]    blink_q, blink_d;
  logic                          adapter_last_q, button_last_q, reset_last_q;
  logic                          led_q, led_d;
  logic                          rail_q, rail_d;
  logic                          stby_q, stby_d;
  logic                          btn_drive_q, btn_drive_d;
  logic                          button_last_d;

  function automatic lps_pkg::pstate_e eval_state(logic s3, logic s5, logic stby);
    lps_pkg::pstate_e s;
    if (s3)        s = lps_pkg::PS_S0;
    else if (s5)   s = lps_pkg::PS_S3;
    else if (stby) s = lps_pkg::PS_S5;
    else           s = lps_pkg::PS_DS5;
    return s;
  endfunction

  always_comb begin
    phase_d       = phase_q;
    cs_d          = cs_q;
    cnt_d         = cnt_q;
    blink_d       = blink_q;
    led_d         = led_q;
    rail_d        = rail_q;
    stby_d        = stby_q;
    btn_drive_d   = btn_drive_q;
    button_last_d = button_last_q;

    // settle wait; on its last tick the rest of the tick runs as idle
    if (phase_d == lps_pkg::PH_SETTLE) begin
      if (cnt_d < {1'b0, cfg_i.settle_ticks}) begin
        cnt_d = cnt_d + 1'b1;
      end else begin
        phase_d = lps_pkg::PH_IDLE;
        cnt_d   = '0;
      end
    end
    if (phase_d != lps_pkg::PH_SETTLE) begin
      cs_d = eval_state(word_i.slp_s3_high, word_i.slp_s5_high, stby_q);
    end

    unique case (phase_d)
      lps_pkg::PH_IDLE: begin
        if (!word_i.button_line && button_last_q) begin
          phase_d = lps_pkg::PH_DEBOUNCE;
          cnt_d   = '0;
        end else begin
          btn_drive_d   = word_i.button_line;
          button_last_d = word_i.button_line;
        end
      end
      lps_pkg::PH_DEBOUNCE: begin
        cnt_d = cnt_d + 1'b1;
        if (word_i.button_line || (!word_i.lid_open && word_i.adapter_absent)) begin
          button_last_d = 1'b1;
          btn_drive_d   = 1'b1;
          phase_d       = lps_pkg::PH_IDLE;
          cnt_d         = '0;
        end else if (cnt_d >= {1'b0, cfg_i.debounce_ticks}) begin
          button_last_d = 1'b0;
          cnt_d         = '0;
          if (cs_d == lps_pkg::PS_DS5) begin
            phase_d = lps_pkg::PH_RAIL;
            rail_d  = 1'b1;
          end else begin
            btn_drive_d = 1'b0;
            phase_d     = lps_pkg::PH_IDLE;
          end
        end
      end
      lps_pkg::PH_RAIL: begin
        cnt_d = cnt_d + 1'b1;
        if (cnt_d == lps_pkg::SeqBtnHigh) btn_drive_d = 1'b1;
        if (cnt_d == lps_pkg::SeqStby)    stby_d      = 1'b1;
        if (cnt_d == lps_pkg::SeqBtnLow)  btn_drive_d = 1'b0;
        if (cnt_d >= lps_pkg::SeqEnd) begin
          cs_d        = eval_state(word_i.slp_s3_high, word_i.slp_s5_high, stby_d);
          btn_drive_d = 1'b0;
          phase_d     = lps_pkg::PH_IDLE;
          cnt_d       = '0;
        end
      end
      default: ;  // still settling
    endcase

    // power LED: solid in S0, blinks in S3, off otherwise
    if (blink_d != lps_pkg::BlinkMax) blink_d = blink_d + 1'b1;
    if (cs_d == lps_pkg::PS_S0) begin
      led_d = 1'b1;
    end else if (cs_d == lps_pkg::PS_S3) begin
      if (blink_d >= cfg_i.blink_ticks) begin
        led_d   = ~led_d;
        blink_d = '0;
      end
    end else begin
      led_d = 1'b0;
    end
  end

  always_comb begin
    word_o.rail_enable         = rail_d;
    word_o.button_out_n        = btn_drive_d;
    word_o.standby_reset_n     = stby_d;
    word_o.power_led           = led_d;
    word_o.amber_led           = word_i.battery_present && !word_i.adapter_absent &&
                                 (word_i.batt_current != '0);
    word_o.white_led           = word_i.battery_present && !word_i.adapter_absent &&
                                 (word_i.batt_current == '0);
    word_o.fan_reset_pulse     = word_i.platform_reset_line && !reset_last_q;
    word_o.charger_enable      = !word_i.adapter_absent;
    word_o.charger_off_pulse   = word_i.adapter_absent && !adapter_last_q;
    word_o.cycle_restart_pulse = word_i.adapter_absent != adapter_last_q;
    word_o.power_state_code    = cs_d;
    word_o.busy_res            = phase_d != lps_pkg::PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= lps_pkg::PH_SETTLE;
      cs_q           <= lps_pkg::PS_DEFAULT;
      cnt_q          <= '0;
      blink_q        <= lps_pkg::BlinkMax;
      adapter_last_q <= 1'b1;
      button_last_q  <= 1'b1;
      reset_last_q   <= 1'b0;
      led_q          <= 1'b0;
      rail_q         <= 1'b0;
      stby_q         <= 1'b0;
      btn_drive_q    <= 1'b1;
    end else if (step_i) begin
      phase_q        <= phase_d;
      cs_q           <= cs_d;
      cnt_q          <= cnt_d;
      blink_q        <= blink_d;
      adapter_last_q <= word_i.adapter_absent;
      button_last_q  <= button_last_d;
      reset_last_q   <= word_i.platform_reset_line;
      led_q          <= led_d;
      rail_q         <= rail_d;
      stby_q         <= stby_d;
      btn_drive_q    <= btn_drive_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/laptop_power_sequencer_core.sv */
// Top level of the laptop power sequencer: input register, tick logic, result
// register and configuration registers. Depends on lps_pkg, lps_cfg, lps_tick.
`default_nettype none

// One input word is one 1 ms tick of sampled board pins; each tick yields
// exactly one result word. A word is held in the input register, where the
// tick logic evaluates it, then waits in the result register until taken, so
// one word per clock flows unless the result register stalls. Throughput is
// limited only by the downstream ready: the input register refills in the
// same cycle the result register is emptied. The user writes configuration
// registers through cfg_we_i only while no tick is in flight; the block does
// not enforce it. Writes to index 3 are ignored. After reset the block counts
// settle_ticks ticks before the power state leaves the default code.
module laptop_power_sequencer_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire lps_pkg::in_word_t         in_word_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output lps_pkg::out_word_t             out_word_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [lps_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [lps_pkg::CfgW-1:0]  cfg_wdata_i
);

  lps_pkg::cfg_t      cfg;
  lps_pkg::in_word_t  in_q;
  lps_pkg::out_word_t res_d, out_q;
  logic               in_valid_q, out_valid_q;
  logic               adv;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  lps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lps_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .word_i (in_q),
    .cfg_i  (cfg),
    .word_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv)              out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q  <= in_word_i;
    if (adv)                      out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result register is stalled");

  a_state_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.power_state_code <= lps_pkg::PS_S0)
    else $error("power state code out of range");

  a_off_implies_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.charger_off_pulse |-> out_word_o.cycle_restart_pulse)
    else $error("charger off pulse without restart pulse");

  a_battery_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.amber_led && out_word_o.white_led))
    else $error("amber and white LEDs both on");

endmodule

`default_nettype wire
